// File: hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 64;
  localparam int LEN_W       = 4;
  localparam int CFG_INDEX_W = 8;
  // Wide enough for the output chain depth at the default parameter values
  localparam int CNT_W       = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES      = 8'd0,
    REG_PATTERN_LENGTH     = 8'd1,
    REG_REPLACEMENT_BYTES  = 8'd2,
    REG_REPLACEMENT_LENGTH = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              end_of_line;
    logic              last_of_run;
  } res_t;

  typedef struct packed {
    logic              load;
    logic              shift;
    logic [BYTE_W-1:0] in_byte;
    logic [LEN_W-1:0]  fill;
    logic [LEN_W-1:0]  plen;
  } win_ctl_t;

  typedef struct packed {
    logic             load;
    logic             pop;
    logic             base;
    logic [CNT_W-1:0] ntot;
  } out_ctl_t;

endpackage

// File: hw/rtl/sfr_if.sv
`timescale 1ns / 1ps

interface sfr_text_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              line_end;
  modport source (output valid, in_byte, line_end, input ready);
  modport sink (input valid, in_byte, line_end, output ready);
endinterface

interface sfr_result_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_present;
  logic              end_of_line;
  logic              last_of_run;
  modport source (output valid, out_byte, byte_present, end_of_line, last_of_run,
                  input ready);
  modport sink (input valid, out_byte, byte_present, end_of_line, last_of_run,
                output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [WORD_W-1:0]      data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// File: hw/rtl/stream_find_and_replace.sv
`timescale 1ns / 1ps

// Streaming find-and-replace over lines of bytes. Text bytes enter on the text channel with
// line_end marking the last byte of a line; results leave on the result channel, one per
// cycle while the result channel is ready, each either a byte or a bare end-of-line marker,
// with last_of_run flagging the final result caused by a text byte. A row of MAX_PATTERN
// window cells holds the bytes that may still start a match; it compares and shifts in the
// same cycle the byte is taken, so the block runs at one byte per cycle while the text
// channel is ready. Results are registered into a chain of output cells whose head drives
// the result channel. The text channel is ready while at most one result is queued, so a
// byte that yields more than one result (up to nine: a replacement or a flush plus the
// marker) holds off the next byte until the output chain has drained back to one result.
// Configuration is accepted in every cycle and must only be written while no results are
// pending; writing pattern_length discards any bytes held in the window.
module stream_find_and_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sfr_text_if.sink     text,
  sfr_result_if.source result,
  sfr_cfg_if.sink      cfg
);
  import sfr_pkg::*;

  localparam int QD = ((MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT) + 2;

  // Configuration registers
  logic [WORD_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic [WORD_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]  replacement_length;

  logic [LEN_W-1:0]  plen;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  fill;
  logic [LEN_W-1:0]  fill_eff;
  logic [LEN_W-1:0]  fill_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic              accept;
  logic              pop;
  logic              full;
  logic              match;
  logic              use_rep;
  logic [CNT_W-1:0]  nb;
  logic [CNT_W-1:0]  ntot;

  win_ctl_t          win_ctl;
  out_ctl_t          out_ctl;

  logic [BYTE_W-1:0] ext [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;
  logic [BYTE_W-1:0] ext_at [QD];
  logic [BYTE_W-1:0] rep_at [QD];
  res_t              entry [QD];
  res_t              held [QD];

  assign cfg.ready = 1'b1;

  always_comb begin
    if (pattern_length == '0) begin
      plen = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      plen = LEN_W'(MAX_PATTERN);
    end else begin
      plen = pattern_length;
    end
    rlen = (replacement_length > LEN_W'(MAX_REPLACEMENT)) ?
           LEN_W'(MAX_REPLACEMENT) : replacement_length;
  end

  assign accept   = text.valid && text.ready;
  assign pop      = result.valid && result.ready;
  assign text.ready = (count <= CNT_W'(1));

  assign fill_eff = (fill >= plen) ? '0 : fill;
  assign full     = (fill_eff + LEN_W'(1)) == plen;
  assign match    = &hit;
  assign use_rep  = full && match;

  always_comb begin
    if (use_rep) begin
      nb = CNT_W'(rlen);
    end else if (text.line_end) begin
      nb = CNT_W'(fill_eff) + CNT_W'(1);
    end else if (full) begin
      nb = CNT_W'(1);
    end else begin
      nb = '0;
    end
    ntot = nb + CNT_W'(text.line_end);
  end

  // Window row
  assign win_ctl.load    = accept;
  assign win_ctl.shift   = full && !match;
  assign win_ctl.in_byte = text.in_byte;
  assign win_ctl.fill    = fill_eff;
  assign win_ctl.plen    = plen;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_win
    logic [BYTE_W-1:0] nbr;
    if (k == MAX_PATTERN - 1) begin : g_tail
      assign nbr = text.in_byte;
    end else begin : g_mid
      assign nbr = ext[k+1];
    end
    sfr_win_cell #(.INDEX(k)) u_cell (
      .clk          (clk),
      .ctl          (win_ctl),
      .neighbor_ext (nbr),
      .pattern_byte (pattern_bytes[BYTE_W*k +: BYTE_W]),
      .ext          (ext[k]),
      .hit          (hit[k])
    );
  end

  // Result sources per slot
  for (genvar j = 0; j < QD; j++) begin : g_src
    if (j < MAX_PATTERN) begin : g_ext
      assign ext_at[j] = ext[j];
    end else begin : g_ext_none
      assign ext_at[j] = '0;
    end
    if (j < MAX_REPLACEMENT) begin : g_rep
      assign rep_at[j] = replacement_bytes[BYTE_W*j +: BYTE_W];
    end else begin : g_rep_none
      assign rep_at[j] = '0;
    end
  end

  always_comb begin
    for (int j = 0; j < QD; j++) begin
      entry[j] = '0;
      if (CNT_W'(j) < nb) begin
        entry[j].out_byte     = use_rep ? rep_at[j] : ext_at[j];
        entry[j].byte_present = 1'b1;
      end else if (text.line_end && (CNT_W'(j) == nb)) begin
        entry[j].end_of_line = 1'b1;
      end
      entry[j].last_of_run = (CNT_W'(j) == (ntot - CNT_W'(1)));
    end
  end

  // Output chain
  assign out_ctl.load = accept;
  assign out_ctl.pop  = pop;
  assign out_ctl.base = (count == CNT_W'(1)) && !pop;
  assign out_ctl.ntot = ntot;

  for (genvar q = 0; q < QD; q++) begin : g_out
    res_t nbr;
    res_t prev;
    if (q == QD - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = held[q+1];
    end
    if (q == 0) begin : g_head
      assign prev = '0;
    end else begin : g_rest
      assign prev = entry[q-1];
    end
    sfr_out_cell #(.INDEX(q)) u_cell (
      .clk           (clk),
      .ctl           (out_ctl),
      .from_neighbor (nbr),
      .entry_here    (entry[q]),
      .entry_prev    (prev),
      .held          (held[q])
    );
  end

  assign result.valid        = (count != '0);
  assign result.out_byte     = held[0].out_byte;
  assign result.byte_present = held[0].byte_present;
  assign result.end_of_line  = held[0].end_of_line;
  assign result.last_of_run  = held[0].last_of_run;

  always_comb begin
    count_next = count - CNT_W'(pop) + (accept ? ntot : '0);
    fill_next  = fill;
    if (cfg.valid && (reg_index_t'(cfg.reg_index) == REG_PATTERN_LENGTH)) begin
      fill_next = '0;
    end else if (accept) begin
      priority if (text.line_end || use_rep) begin
        fill_next = '0;
      end else if (full) begin
        fill_next = fill_eff;
      end else begin
        fill_next = fill_eff + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
      fill               <= '0;
      count              <= '0;
    end else begin
      fill  <= fill_next;
      count <= count_next;
      if (cfg.valid) begin
        unique case (reg_index_t'(cfg.reg_index))
          REG_PATTERN_BYTES:      pattern_bytes      <= cfg.data;
          REG_PATTERN_LENGTH:     pattern_length     <= cfg.data[LEN_W-1:0];
          REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg.data;
          REG_REPLACEMENT_LENGTH: replacement_length <= cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QD))
    else $error("output chain overfilled");

  a_fill_below_plen: assert property (@(posedge clk) disable iff (rst)
    fill < plen)
    else $error("window fill reached pattern length");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && text.line_end) |=> (fill == '0))
    else $error("window not flushed at end of line");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (pop && (count == CNT_W'(1)) && !accept) |=> !result.valid)
    else $error("result still shown after last one was taken");
`endif

endmodule

// File: hw/rtl/sfr_win_cell.sv
`timescale 1ns / 1ps

module sfr_win_cell #(
  parameter int INDEX = 0
) (
  input  logic                            clk,
  input  sfr_pkg::win_ctl_t               ctl,
  input  logic [sfr_pkg::BYTE_W-1:0]      neighbor_ext,
  input  logic [sfr_pkg::BYTE_W-1:0]      pattern_byte,
  output logic [sfr_pkg::BYTE_W-1:0]      ext,
  output logic                            hit
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] held;
  logic              in_use;

  // The incoming byte lands in the first free slot; view it there already
  assign ext    = (LEN_W'(INDEX) < ctl.fill) ? held : ctl.in_byte;
  assign in_use = LEN_W'(INDEX) < ctl.plen;
  assign hit    = !in_use || (ext == pattern_byte);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= ctl.shift ? neighbor_ext : ext;
    end
  end

endmodule

// File: hw/rtl/sfr_out_cell.sv
`timescale 1ns / 1ps

module sfr_out_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  sfr_pkg::out_ctl_t ctl,
  input  sfr_pkg::res_t     from_neighbor,
  input  sfr_pkg::res_t     entry_here,
  input  sfr_pkg::res_t     entry_prev,
  output sfr_pkg::res_t     held
);
  import sfr_pkg::*;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] rel;
  logic             in_range;
  res_t             held_next;

  assign idx      = CNT_W'(INDEX);
  assign rel      = idx - CNT_W'(ctl.base);
  assign in_range = ctl.load && (idx >= CNT_W'(ctl.base)) && (rel < ctl.ntot);

  always_comb begin
    if (in_range) begin
      held_next = ctl.base ? entry_prev : entry_here;
    end else if (ctl.pop) begin
      held_next = from_neighbor;
    end else begin
      held_next = held;
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
  end

endmodule
